@@ hdl/hed_pkg.sv @@
// Shared constants, types and entity tables for the HTML character reference decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package hed_pkg;

   localparam int NAME_WINDOW = 16;
   localparam int HELD_IDX_W  = $clog2(NAME_WINDOW);
   localparam int CNT_W       = HELD_IDX_W + 1;
   localparam int NUM_REFS    = 16;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

   localparam logic [7:0]  CH_AMP  = 8'h26;
   localparam logic [7:0]  CH_SEMI = 8'h3B;
   localparam logic [7:0]  CH_HASH = 8'h23;
   localparam logic [30:0] CP_MAX  = 31'h7FFF_FFFF;

   // key text right-aligned, first character in the highest used byte
   localparam logic [47:0] KEY_TAB [NUM_REFS] = '{
      48'("lt"), 48'("gt"), 48'("amp"), 48'("apos"), 48'("quot"),
      48'("lsquo"), 48'("rsquo"), 48'("ldquo"), 48'("rdquo"), 48'("nbsp"),
      48'("trade"), 48'("copy"), 48'("reg"), 48'("hellip"), 48'("mdash"),
      48'("euro")};
   localparam logic [2:0] KEY_LEN [NUM_REFS] = '{
      3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4,
      3'd5, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4};
   // replacement bytes, first byte lowest
   localparam logic [23:0] SEQ_TAB [NUM_REFS] = '{
      24'h00003C, 24'h00003E, 24'h000026, 24'h000027, 24'h000022,
      24'h9880E2, 24'h9980E2, 24'h9C80E2, 24'h9D80E2, 24'h00A0C2,
      24'hA284E2, 24'h00A9C2, 24'h00AEC2, 24'hA680E2, 24'h9480E2,
      24'hAC82E2};
   localparam logic [1:0] SEQ_LEN [NUM_REFS] = '{
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2,
      2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_amp;
      logic       is_semi;
   } hed_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] held_count;
      logic             open;
   } hed_status_type;

endpackage
`default_nettype wire

@@ hdl/hed_front.sv @@
// Front end: accepts source bytes, tags ampersand and semicolon, queues them.
// Depends on hed_pkg.
`default_nettype none
module hed_front import hed_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] in_byte
   input  wire logic         req_tlast,
   output logic              q_valid,
   output hed_item_type      q_item,
   input  wire logic         q_pop
);

   hed_item_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_PTR_W:0]      cnt_ff, cnt_in;
   logic                     push;
   hed_item_type             new_item;

   assign req_tready = (cnt_ff != (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != '0);
   assign q_item     = mem_ff[rd_ff];

   always_comb begin
      new_item.data    = req_tdata;
      new_item.last    = req_tlast;
      new_item.is_amp  = (req_tdata == CH_AMP);
      new_item.is_semi = (req_tdata == CH_SEMI);
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= new_item;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/hed_back.sv @@
// Back end: holds entity names, decodes them and emits result bytes one per cycle
// when the output is not stalled. Depends on hed_pkg; fed by hed_front.
`default_nettype none
module hed_back import hed_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  hed_item_type      q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,
   output hed_status_type    status
);

   localparam logic [2:0] S_TAKE   = 3'd0;
   localparam logic [2:0] S_LIT    = 3'd1;
   localparam logic [2:0] S_UTF8   = 3'd2;
   localparam logic [2:0] S_TAB    = 3'd3;
   localparam logic [2:0] S_AMP    = 3'd4;
   localparam logic [2:0] S_RESCAN = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic                    open_ff, open_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [7:0]              held_ff [NAME_WINDOW];
   logic                    num_ff, num_in, dig_ff, dig_in;
   logic [30:0]             val_ff, val_in;
   logic [NUM_REFS-1:0]     mask_ff, mask_in;
   logic                    last_ff, last_in, semi_ff, semi_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [3:0]              tab_ff, tab_in;
   logic [2:0]              nb_ff, nb_in;
   logic                    ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [7:0]              odata_ff, odata_in;

   logic                    out_free, append;
   logic [7:0]              app_b, rescan_b;
   logic                    a_num, a_dig;
   logic [30:0]             a_val;
   logic [NUM_REFS-1:0]     a_mask, m_base;
   logic [35:0]             prod;
   logic                    hit;
   logic [3:0]              hit_k;
   logic [2:0]              cp_len, sh;
   logic [30:0]             shifted;
   logic [7:0]              utf_b;
   logic [CNT_W-1:0]        lit_end;
   logic [2:0]              kidx;

   assign out_free   = !ovalid_ff || rsp_tready;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign status.held_count = count_ff;
   assign status.open       = open_ff;
   assign rescan_b   = held_ff[idx_ff[HELD_IDX_W-1:0]];
   assign app_b      = (state_ff == S_RESCAN) ? rescan_b : q_item.data;

   // incremental name parse for the byte being appended at position count_ff
   always_comb begin
      a_num  = num_ff;
      a_dig  = dig_ff;
      a_val  = val_ff;
      m_base = mask_ff;
      prod   = ({5'd0, val_ff} << 3) + ({5'd0, val_ff} << 1) + 36'(app_b - 8'h30);
      if (count_ff == '0) begin
         a_num  = (app_b == CH_HASH);
         a_dig  = (app_b == CH_HASH);
         a_val  = '0;
         m_base = '1;
      end else if (dig_ff) begin
         if (app_b inside {[8'h30:8'h39]}) begin
            a_val = (prod > 36'(CP_MAX)) ? CP_MAX : prod[30:0];
         end else begin
            a_dig = 1'b0;
         end
      end
      for (int k = 0; k < NUM_REFS; k++) begin
         kidx      = KEY_LEN[k] - 3'd1 - count_ff[2:0];
         a_mask[k] = m_base[k] && (count_ff < CNT_W'(KEY_LEN[k]))
                     && (KEY_TAB[k][8*kidx +: 8] == app_b);
      end
   end

   always_comb begin
      hit   = 1'b0;
      hit_k = '0;
      for (int k = NUM_REFS-1; k >= 0; k--) begin
         if (mask_ff[k] && count_ff != '0 && count_ff == CNT_W'(KEY_LEN[k])) begin
            hit   = 1'b1;
            hit_k = 4'(k);
         end
      end
      if (val_ff < 31'h80)             cp_len = 3'd1;
      else if (val_ff < 31'h800)       cp_len = 3'd2;
      else if (val_ff < 31'h10000)     cp_len = 3'd3;
      else if (val_ff < 31'h200000)    cp_len = 3'd4;
      else if (val_ff < 31'h4000000)   cp_len = 3'd5;
      else                             cp_len = 3'd6;
      sh      = nb_ff - 3'd1 - idx_ff[2:0];
      shifted = val_ff >> (5'(sh) * 5'd6);
      if (nb_ff == 3'd1) begin
         utf_b = val_ff[7:0];
      end else if (idx_ff == '0) begin
         case (nb_ff)
            3'd2:    utf_b = 8'hC0 | shifted[7:0];
            3'd3:    utf_b = 8'hE0 | shifted[7:0];
            3'd4:    utf_b = 8'hF0 | shifted[7:0];
            3'd5:    utf_b = 8'hF8 | shifted[7:0];
            default: utf_b = 8'hFC | shifted[7:0];
         endcase
      end else begin
         utf_b = {2'b10, shifted[5:0]};
      end
      lit_end = semi_ff ? count_ff + 1'b1 : count_ff;
   end

   always_comb begin
      state_in  = state_ff;
      open_in   = open_ff;
      count_in  = count_ff;
      num_in    = num_ff;
      dig_in    = dig_ff;
      val_in    = val_ff;
      mask_in   = mask_ff;
      last_in   = last_ff;
      semi_in   = semi_ff;
      idx_in    = idx_ff;
      tab_in    = tab_ff;
      nb_in     = nb_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      q_pop     = 1'b0;
      append    = 1'b0;
      case (state_ff)
         S_TAKE: begin
            if (q_valid && out_free) begin
               q_pop   = 1'b1;
               last_in = q_item.last;
               idx_in  = '0;
               semi_in = 1'b0;
               if (!open_ff) begin
                  if (q_item.is_amp) begin
                     open_in  = 1'b1;
                     count_in = '0;
                     num_in   = 1'b0;
                     dig_in   = 1'b0;
                     val_in   = '0;
                     mask_in  = '1;
                     if (q_item.last) state_in = S_LIT;
                  end else begin
                     ovalid_in = 1'b1;
                     odata_in  = q_item.data;
                     olast_in  = q_item.last;
                  end
               end else if (q_item.is_semi) begin
                  open_in = 1'b0;
                  if (num_ff && val_ff != '0) begin
                     nb_in    = cp_len;
                     state_in = S_UTF8;
                  end else if (hit) begin
                     tab_in   = hit_k;
                     state_in = S_TAB;
                  end else begin
                     semi_in  = 1'b1;
                     state_in = S_LIT;
                  end
               end else begin
                  append   = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (count_in == CNT_W'(NAME_WINDOW)) state_in = S_AMP;
                  else if (q_item.last)                state_in = S_LIT;
               end
            end
         end
         S_LIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               olast_in  = last_ff && (idx_ff == lit_end);
               if (idx_ff == '0)           odata_in = CH_AMP;
               else if (idx_ff > count_ff) odata_in = CH_SEMI;
               else odata_in = held_ff[HELD_IDX_W'(idx_ff - 1'b1)];
               idx_in = idx_ff + 1'b1;
               if (idx_ff == lit_end) begin
                  open_in  = 1'b0;
                  count_in = '0;
                  state_in = S_TAKE;
               end
            end
         end
         S_UTF8: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = utf_b;
               olast_in  = last_ff && (idx_ff[2:0] == nb_ff - 3'd1);
               idx_in    = idx_ff + 1'b1;
               if (idx_ff[2:0] == nb_ff - 3'd1) begin
                  count_in = '0;
                  state_in = S_TAKE;
               end
            end
         end
         S_TAB: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = SEQ_TAB[tab_ff][8*idx_ff[1:0] +: 8];
               olast_in  = last_ff && (idx_ff[1:0] == SEQ_LEN[tab_ff] - 2'd1);
               idx_in    = idx_ff + 1'b1;
               if (idx_ff[1:0] == SEQ_LEN[tab_ff] - 2'd1) begin
                  count_in = '0;
                  state_in = S_TAKE;
               end
            end
         end
         S_AMP: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = CH_AMP;
               olast_in  = 1'b0;
               open_in   = 1'b0;
               count_in  = '0;
               idx_in    = '0;
               state_in  = S_RESCAN;
            end
         end
         S_RESCAN: begin
            if (out_free) begin
               if (open_ff) begin
                  append   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else if (rescan_b == CH_AMP) begin
                  open_in  = 1'b1;
                  count_in = '0;
                  num_in   = 1'b0;
                  dig_in   = 1'b0;
                  val_in   = '0;
                  mask_in  = '1;
               end else begin
                  ovalid_in = 1'b1;
                  odata_in  = rescan_b;
                  olast_in  = last_ff && (idx_ff == CNT_W'(NAME_WINDOW - 1));
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == CNT_W'(NAME_WINDOW - 1)) begin
                  idx_in  = '0;
                  semi_in = 1'b0;
                  if (last_ff && open_in) state_in = S_LIT;
                  else                    state_in = S_TAKE;
               end
            end
         end
         default: begin
            state_in = S_TAKE;
         end
      endcase
      if (append) begin
         num_in  = a_num;
         dig_in  = a_dig;
         val_in  = a_val;
         mask_in = a_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (append) begin
         held_ff[count_ff[HELD_IDX_W-1:0]] <= app_b;
      end
      num_ff   <= num_in;
      dig_ff   <= dig_in;
      val_ff   <= val_in;
      mask_ff  <= mask_in;
      last_ff  <= last_in;
      semi_ff  <= semi_in;
      idx_ff   <= idx_in;
      tab_ff   <= tab_in;
      nb_ff    <= nb_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
      if (reset) begin
         state_ff  <= S_TAKE;
         open_ff   <= 1'b0;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         open_ff   <= open_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/html_entity_decoder_core.sv @@
// Top level of the HTML character reference decoder: front queue plus decode engine.
// Depends on hed_pkg, hed_front and hed_back.
//
//  channel  dir  payload                        handshake
//  req_*    in   tdata = in_byte, tlast=in_last  tvalid/tready
//  rsp_*    out  tdata = out_byte, tlast=out_last tvalid/tready
//
// One result byte per cycle unless the output stalls; a plain byte is passed on.
// A closed name resolves when its semicolon is taken, then its result bytes follow;
// a full window emits the ampersand and rescans the 16 held bytes, and emits the
// held bytes as well if the string ends.
// The engine pace sets the rate; a 4-entry queue decouples input from engine.
// Reset is synchronous and clears control state only. Either side may stall freely.
`default_nettype none
module html_entity_decoder_core import hed_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] in_byte
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast
);

   logic            q_valid, q_pop;
   hed_item_type    q_item;
   hed_status_type  status;

   hed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   hed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (status)
   );

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      status.held_count <= CNT_W'(NAME_WINDOW))
      else $error("held count beyond window");

   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(status.open) && q_pop |=> status.held_count == '0 || status.open)
      else $error("name closed without clearing hold");
`endif

endmodule
`default_nettype wire
